/* rtl/bfa_pkg.sv */
`default_nettype none

package bfa_pkg;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam int unsigned CountW = 5;
  localparam int unsigned IndexW = 4;
  localparam int unsigned SizeW  = 16;

  localparam logic [CountW-1:0] BlockCountReset = CountW'(16);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } bfa_state_e;

  typedef struct packed {
    logic              granted;
    logic [IndexW-1:0] chosen_block;
    logic [SizeW-1:0]  space_left;
  } bfa_result_t;

endpackage

`default_nettype wire

/* rtl/bfa_ram.sv */
`default_nettype none

module bfa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/bfa_scan.sv */
`default_nettype none

module bfa_scan import bfa_pkg::*; #(
  parameter int unsigned NumBlocks = 16,
  parameter int unsigned SizeBits  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output      logic                         busy_o,
  input  wire logic                         action_i,
  input  wire logic [IndexW-1:0]            load_index_i,
  input  wire logic [SizeW-1:0]             size_value_i,
  input  wire logic [CountW-1:0]            block_count_i,
  output      logic                         done_o,
  output      bfa_result_t                  result_o,
  output      logic                         ram_we_o,
  output      logic [$clog2(NumBlocks)-1:0] ram_waddr_o,
  output      logic [SizeBits-1:0]          ram_wdata_o,
  output      logic [$clog2(NumBlocks)-1:0] ram_raddr_o,
  input  wire logic [SizeBits-1:0]          ram_rdata_i
);

  localparam int unsigned IdxW = $clog2(NumBlocks);
  localparam int unsigned CntW = $clog2(NumBlocks + 1);
  localparam int unsigned CmpW = (CntW > CountW) ? CntW : CountW;
  localparam logic [CmpW-1:0] NumBlocksC = CmpW'(NumBlocks);

  bfa_state_e state_q, state_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                pend_q, pend_d;
  logic                pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic [SizeBits-1:0] req_q, req_d;
  logic                found_q, found_d;
  logic [SizeBits-1:0] best_v_q, best_v_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic                done_q, done_d;
  bfa_result_t         result_q, result_d;
  logic [NumBlocks-1:0] valid_q;

  logic [CmpW-1:0]     count_ext;
  logic [CmpW-1:0]     limit;
  logic [SizeBits-1:0] entry_v;
  logic [SizeBits-1:0] new_v;
  logic                load_in_range;

  assign count_ext     = CmpW'(block_count_i);
  assign limit         = (count_ext > NumBlocksC) ? NumBlocksC : count_ext;
  assign entry_v       = pend_vld_q ? ram_rdata_i : '0;
  assign new_v         = best_v_q - req_q;
  assign load_in_range = (32'(load_index_i) < NumBlocks);
  assign ram_raddr_o   = issue_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    req_d       = req_q;
    found_d     = found_q;
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    done_d      = 1'b0;
    result_d    = result_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = best_idx_q;
    ram_wdata_o = new_v;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_LOAD) begin
            ram_we_o    = load_in_range;
            ram_waddr_o = IdxW'(load_index_i);
            ram_wdata_o = SizeBits'(size_value_i);
          end else begin
            req_d   = SizeBits'(size_value_i);
            issue_d = '0;
            pend_d  = 1'b0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_q && (entry_v >= req_q) && (!found_q || (best_v_q > entry_v))) begin
          found_d    = 1'b1;
          best_v_d   = entry_v;
          best_idx_d = pend_idx_q;
        end
        if (CmpW'(issue_q) < limit) begin
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IdxW-1:0];
          pend_vld_d = valid_q[issue_q[IdxW-1:0]];
          issue_d    = issue_q + CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        ram_we_o              = found_q;
        done_d                = 1'b1;
        result_d.granted      = found_q;
        result_d.chosen_block = found_q ? IndexW'(best_idx_q) : '0;
        result_d.space_left   = found_q ? SizeW'(new_v) : '0;
        state_d               = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (ram_we_o) begin
        valid_q[ram_waddr_o] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vld_q <= pend_vld_d;
    pend_idx_q <= pend_idx_d;
    req_q      <= req_d;
    best_v_q   <= best_v_d;
    best_idx_q <= best_idx_d;
    result_q   <= result_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

/* rtl/best_fit_block_allocator_top.sv */
// Load word: written from idle; start is taken again on the next cycle.
// Allocate word: the free-size RAM is read one entry per cycle over the first
// min(block_count, NUM_BLOCKS) entries, then S_WRITE writes the best fit back
// if one was found. One word in flight at a time; done_o pulses one cycle
// and cannot be stalled. Reset clears the control state and the per-entry
// valid bits, so the table reads as all zero at once; block_count resets to 16.
`default_nettype none

module best_fit_block_allocator_top import bfa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              action_i,
  input  wire logic [IndexW-1:0] load_index_i,
  input  wire logic [SizeW-1:0]  size_value_i,
  output      logic              done_o,
  output      logic              granted_o,
  output      logic [IndexW-1:0] chosen_block_o,
  output      logic [SizeW-1:0]  space_left_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(NUM_BLOCKS);

  logic [CountW-1:0]    block_count_q;
  bfa_result_t          result;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [IdxW-1:0]      ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BlockCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      block_count_q <= cfg_data_i;
    end
  end

  bfa_scan #(
    .NumBlocks (NUM_BLOCKS),
    .SizeBits  (SIZE_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .action_i      (action_i),
    .load_index_i  (load_index_i),
    .size_value_i  (size_value_i),
    .block_count_i (block_count_q),
    .done_o        (done_o),
    .result_o      (result),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  bfa_ram #(
    .Width (SIZE_BITS),
    .Depth (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign granted_o      = result.granted;
  assign chosen_block_o = result.chosen_block;
  assign space_left_o   = result.space_left;

endmodule

`default_nettype wire
